FILE: rtl/dq_pkg.sv
`default_nettype none

package dq_pkg;

  // ring store geometry
  localparam int DEPTH       = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int DUMP_CAP    = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

  // word field widths
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FQ_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FQ_FILL_W  = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [CMD_W-1:0]          cmd_code_t;
  typedef logic [STATUS_W-1:0]       status_t;

  localparam cnt_t DUMP_CAP_C = CNT_W'(DUMP_CAP);
  localparam cnt_t DEPTH_C    = CNT_W'(DEPTH);

  // command codes on the input channel
  localparam cmd_code_t CMD_PUSH_FRONT = CMD_W'(0);
  localparam cmd_code_t CMD_PUSH_BACK  = CMD_W'(1);
  localparam cmd_code_t CMD_POP_FRONT  = CMD_W'(2);
  localparam cmd_code_t CMD_POP_BACK   = CMD_W'(3);
  localparam cmd_code_t CMD_DUMP       = CMD_W'(4);

  // status codes on the result channel
  localparam status_t ST_OK    = STATUS_W'(0);
  localparam status_t ST_EMPTY = STATUS_W'(1);
  localparam status_t ST_FULL  = STATUS_W'(2);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP
  } op_t;

  typedef struct packed {
    op_t    op;
    value_t value;
  } cmd_word_t;

  // (base + off) mod DEPTH, both operands below DEPTH
  function automatic idx_t ring_add(idx_t base, idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // (base - 1) mod DEPTH
  function automatic idx_t ring_dec(idx_t base);
    idx_t res;
    if (base == '0) begin
      res = IDX_W'(DEPTH - 1);
    end else begin
      res = base - IDX_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dq_front.sv
`default_nettype none

module dq_front (
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  input  wire dq_pkg::cmd_code_t command,
  input  wire dq_pkg::value_t    value,
  input  wire logic              q_full,
  output logic                   q_push,
  output dq_pkg::cmd_word_t      q_word
);

  logic known;

  // decode command code, unused codes are dropped
  always_comb begin
    known      = 1'b1;
    q_word.op  = dq_pkg::OP_DUMP;
    q_word.value = value;
    case (command)
      dq_pkg::CMD_PUSH_FRONT: q_word.op = dq_pkg::OP_PUSH_FRONT;
      dq_pkg::CMD_PUSH_BACK:  q_word.op = dq_pkg::OP_PUSH_BACK;
      dq_pkg::CMD_POP_FRONT:  q_word.op = dq_pkg::OP_POP_FRONT;
      dq_pkg::CMD_POP_BACK:   q_word.op = dq_pkg::OP_POP_BACK;
      dq_pkg::CMD_DUMP:       q_word.op = dq_pkg::OP_DUMP;
      default:                known     = 1'b0;
    endcase
  end

  assign cmd_stall = q_full;
  assign q_push    = cmd_valid && !q_full && known;

endmodule

`default_nettype wire

FILE: rtl/dq_cmd_fifo.sv
`default_nettype none

module dq_cmd_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dq_pkg::cmd_word_t push_word,
  input  wire logic              pop,
  output logic                   full,
  output logic                   empty,
  output dq_pkg::cmd_word_t      head
);

  dq_pkg::cmd_word_t slots [dq_pkg::FIFO_DEPTH];
  logic [dq_pkg::FQ_PTR_W-1:0]  wr_ptr;
  logic [dq_pkg::FQ_PTR_W-1:0]  rd_ptr;
  logic [dq_pkg::FQ_FILL_W-1:0] fill;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (fill == dq_pkg::FQ_FILL_W'(dq_pkg::FIFO_DEPTH));
  assign empty   = (fill == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == dq_pkg::FQ_PTR_W'(dq_pkg::FIFO_DEPTH - 1)) ? '0
                  : wr_ptr + dq_pkg::FQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == dq_pkg::FQ_PTR_W'(dq_pkg::FIFO_DEPTH - 1)) ? '0
                  : rd_ptr + dq_pkg::FQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + dq_pkg::FQ_FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - dq_pkg::FQ_FILL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dq_back.sv
`default_nettype none

module dq_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_empty,
  input  wire dq_pkg::cmd_word_t          q_head,
  output logic                            q_pop,
  output logic                            res_valid,
  input  wire logic                       res_stall,
  output dq_pkg::value_t                  value_res,
  output dq_pkg::status_t                 status,
  output logic [dq_pkg::COUNT_W-1:0]      count,
  output logic                            last
);

  // ring store, contents undefined until written
  dq_pkg::value_t store [dq_pkg::DEPTH];
  dq_pkg::value_t rd_data;

  dq_pkg::idx_t front;
  dq_pkg::idx_t front_next;
  dq_pkg::cnt_t cnt;
  dq_pkg::cnt_t cnt_next;
  dq_pkg::idx_t dump_idx;
  dq_pkg::idx_t dump_idx_next;
  logic         from_mem;

  logic            load;
  logic            wr_en;
  dq_pkg::idx_t    wr_addr;
  logic            rd_en;
  dq_pkg::idx_t    rd_addr;
  dq_pkg::status_t st;
  logic            lst;
  logic            is_full;
  logic            is_empty;
  dq_pkg::cnt_t    dump_n;
  logic            dump_last;

  // take the next result whenever the output register is free or draining
  assign load     = !q_empty && (!res_valid || !res_stall);
  assign is_full  = (cnt >= dq_pkg::DEPTH_C);
  assign is_empty = (cnt == '0);
  assign dump_n   = (cnt > dq_pkg::DUMP_CAP_C) ? dq_pkg::DUMP_CAP_C : cnt;
  assign dump_last = ((dq_pkg::CNT_W'(dump_idx) + dq_pkg::CNT_W'(1)) == dump_n);

  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = front;
    rd_en         = 1'b0;
    rd_addr       = front;
    front_next    = front;
    cnt_next      = cnt;
    dump_idx_next = dump_idx;
    st            = dq_pkg::ST_OK;
    lst           = 1'b1;
    q_pop         = 1'b0;
    if (load) begin
      q_pop = 1'b1;
      case (q_head.op)
        dq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            st = dq_pkg::ST_FULL;
          end else begin
            front_next = dq_pkg::ring_dec(front);
            wr_en      = 1'b1;
            wr_addr    = front_next;
            cnt_next   = cnt + dq_pkg::CNT_W'(1);
          end
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            st = dq_pkg::ST_FULL;
          end else begin
            wr_en    = 1'b1;
            wr_addr  = dq_pkg::ring_add(front, dq_pkg::IDX_W'(cnt));
            cnt_next = cnt + dq_pkg::CNT_W'(1);
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (is_empty) begin
            st = dq_pkg::ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = front;
            front_next = dq_pkg::ring_add(front, dq_pkg::IDX_W'(1));
            cnt_next   = cnt - dq_pkg::CNT_W'(1);
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (is_empty) begin
            st = dq_pkg::ST_EMPTY;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = dq_pkg::ring_add(front, dq_pkg::IDX_W'(cnt - dq_pkg::CNT_W'(1)));
            cnt_next = cnt - dq_pkg::CNT_W'(1);
          end
        end
        dq_pkg::OP_DUMP: begin
          if (is_empty) begin
            st = dq_pkg::ST_EMPTY;
          end else begin
            // one element per result, command retires on the last one
            rd_en   = 1'b1;
            rd_addr = dq_pkg::ring_add(front, dump_idx);
            lst     = dump_last;
            q_pop   = dump_last;
            dump_idx_next = dump_last ? '0 : dump_idx + dq_pkg::IDX_W'(1);
          end
        end
        default: begin
          st = dq_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= q_head.value;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status   <= st;
      count    <= dq_pkg::COUNT_W'(cnt_next);
      last     <= lst;
      from_mem <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      cnt       <= '0;
      dump_idx  <= '0;
      res_valid <= 1'b0;
    end else begin
      front     <= front_next;
      cnt       <= cnt_next;
      dump_idx  <= dump_idx_next;
      res_valid <= load || (res_valid && res_stall);
    end
  end

  assign value_res = from_mem ? rd_data : '0;

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue_unit.sv
`default_nettype none

// channel   direction  handshake             payload
// cmd       in         cmd_valid / cmd_stall command, value
// res       out        res_valid / res_stall value_res, status, count, last
//
// push and pop: handled in a single step by the back end, result registered when
// the command word at the head of the two-word command queue is taken
// dump: min(count, 32) words, one per cycle while not stalled, one store read each
// reset: synchronous, clears pointers, count and queues; the store is not cleared
// since no entry is read before it is written
// stalls: res_stall holds the result register; the input stalls once the queue fills

module double_ended_queue_unit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // command channel
  input  wire logic                   cmd_valid,
  output logic                        cmd_stall,
  input  wire logic [2:0]             command,
  input  wire logic signed [31:0]     value,
  // result channel
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output logic signed [31:0]          value_res,
  output logic [1:0]                  status,
  output logic [5:0]                  count,
  output logic                        last
);

  // front to queue
  logic              q_push;
  dq_pkg::cmd_word_t q_word;
  logic              q_full;
  // queue to back
  logic              q_pop;
  logic              q_empty;
  dq_pkg::cmd_word_t q_head;

  // decode and drop unused command codes
  dq_front u_front (
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .value     (value),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_word    (q_word)
  );

  // decouples input acceptance from the back end's dump streaming
  dq_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_word),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // ring store, pointers, dump sequencer and result register
  dq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .value_res (value_res),
    .status    (status),
    .count     (count),
    .last      (last)
  );

endmodule

`default_nettype wire

FILE: rtl/dq_checker.sv
`default_nettype none

module dq_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cmd_valid,
  input wire logic               cmd_stall,
  input wire logic [2:0]         command,
  input wire logic signed [31:0] value,
  input wire logic               res_valid,
  input wire logic               res_stall,
  input wire logic signed [31:0] value_res,
  input wire logic [1:0]         status,
  input wire logic [5:0]         count,
  input wire logic               last
);

  // no result word right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(value_res) && $stable(status)
      && $stable(count) && $stable(last))
    else $error("stalled result changed");

  // empty error: count zero, no value, single word
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == dq_pkg::ST_EMPTY |-> count == '0 && last && value_res == '0)
    else $error("bad empty result");

  // full error: count at capacity, no value, single word
  a_full_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == dq_pkg::ST_FULL |->
      count == dq_pkg::COUNT_W'(dq_pkg::DEPTH) && last && value_res == '0)
    else $error("bad full result");

  // only a good dump produces non-final words
  a_mid_dump_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> status == dq_pkg::ST_OK)
    else $error("error status on non-final word");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (.*);

`default_nettype wire
